/* rtl/core/dtep_pkg.sv */
// ----------------------------------------------------------------------------
// dtep_pkg: shared types and constants for datetime text to epoch seconds
// Holds the character codes, calendar constants, the per-string record
// passed from the tokenizer to the calendar unit, and the back-end states.
// ----------------------------------------------------------------------------
`default_nettype none

package dtep_pkg;

  // field limits
  localparam int unsigned MAX_FIELDS  = 6;
  localparam int unsigned FIELD_SLOTS = 6;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  // separator and digit characters
  localparam logic [7:0]  CHAR_SPACE = 8'h20;
  localparam logic [7:0]  CHAR_COLON = 8'h3a;
  localparam logic [7:0]  CHAR_DASH  = 8'h2d;
  localparam logic [31:0] CHAR_ZERO  = 32'd48;

  // fewest fields that make a date
  localparam logic [CNT_W-1:0] MIN_FIELDS = 3'd3;

  // calendar arithmetic
  localparam int unsigned DAYS_W = 44;
  localparam int unsigned TOD_W  = 46;
  // bias that lifts floor(y/4) above zero; a multiple of 25
  localparam logic signed [32:0] DIV25_BIAS   = 33'sd1677721600;
  localparam logic [28:0]        DIV25_UNBIAS = 29'd67108864;
  // ceil(2^36 / 25) and ceil(2^19 / 5)
  localparam logic [31:0] RECIP25 = 32'd2748779070;
  localparam logic [16:0] RECIP5  = 17'd104858;
  localparam logic signed [DAYS_W-1:0] EPOCH_SHIFT = 44'sd719468;

  // one closed string, as handed to the calendar unit
  typedef struct packed {
    logic [31:0]      year;
    logic [7:0]       month;
    logic [7:0]       day;
    logic [31:0]      hour;
    logic [31:0]      minute;
    logic [31:0]      second;
    logic [CNT_W-1:0] count;
  } dtep_rec_t;

  // calendar unit sequence
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DAYS,
    ST_SEC
  } dtep_state_e;

endpackage

`default_nettype wire

/* rtl/core/datetime_text_to_epoch_seconds_top.sv */
// ----------------------------------------------------------------------------
// datetime_text_to_epoch_seconds_top: date or datetime text to epoch seconds
// Streams a string one character per transaction and returns one result per
// string: seconds since 1970-01-01 00:00:00, or a too-few-fields flag.
// ----------------------------------------------------------------------------
// Input channel: text_byte_i with is_last_i marking the final character,
// moved on in_valid_i high and in_stall_o low; one character per cycle.
// Output channel: epoch_seconds_o and too_few_fields_o, moved on
// out_valid_o high and out_stall_i low; one transaction per string.
// Configuration: cfg_we_i writes include_time from cfg_wdata_i (reset 1).
// A result passes from the queue via the prep, multiply, days and seconds
// steps to the output register. Characters stream at one per cycle when
// not stalled; the calendar unit takes one string at a time.
// A two-entry queue between tokenizer and calendar unit absorbs strings;
// when it is full in_stall_o rises until the calendar unit frees an entry.
// A stalled result holds in the output register, and the calendar unit
// then waits in its last step. Reset empties the queue and output and
// clears the running field value and field count.
// ----------------------------------------------------------------------------
`default_nettype none

module datetime_text_to_epoch_seconds_top #(
  parameter int unsigned MaxFields  = dtep_pkg::MAX_FIELDS,
  parameter int unsigned QueueDepth = dtep_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        is_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      epoch_seconds_o,
  output logic             too_few_fields_o
);

  dtep_pkg::dtep_rec_t push_rec;
  dtep_pkg::dtep_rec_t head_rec;
  logic                push;
  logic                pop;
  logic                full;
  logic                empty;

  // tokenizer
  dtep_front #(
    .MaxFields (MaxFields)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_byte_i (text_byte_i),
    .is_last_i   (is_last_i),
    .full_i      (full),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  // record queue
  dtep_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .rec_o   (head_rec)
  );

  // calendar unit
  dtep_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .empty_i          (empty),
    .rec_i            (head_rec),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .epoch_seconds_o  (epoch_seconds_o),
    .too_few_fields_o (too_few_fields_o)
  );

endmodule

`default_nettype wire

/* rtl/core/dtep_front.sv */
// ----------------------------------------------------------------------------
// dtep_front: character tokenizer
// Takes one character per cycle while the queue is not full, builds the running field value, closes
// fields on separators and on the final character, and pushes the record.
// ----------------------------------------------------------------------------
`default_nettype none

module dtep_front #(
  parameter int unsigned MaxFields = dtep_pkg::MAX_FIELDS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        text_byte_i,
  input  wire logic              is_last_i,
  input  wire logic              full_i,
  output logic                   push_o,
  output dtep_pkg::dtep_rec_t    rec_o
);

  localparam logic [dtep_pkg::CNT_W-1:0] MaxCnt = dtep_pkg::CNT_W'(MaxFields);

  logic [31:0]                acc_q, acc_d;
  logic [dtep_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]                fld_q [MaxFields];
  logic [31:0]                fld_fin [MaxFields];
  logic [31:0]                slot [dtep_pkg::FIELD_SLOTS];

  logic                       accept;
  logic                       sep;
  logic [31:0]                digit;
  logic [31:0]                acc_step;
  logic                       wr1_en, wr2_en;
  logic [dtep_pkg::CNT_W-1:0] cnt1, cnt2;

  // stall input characters while the queue is full
  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // separator test and running value
  always_comb begin
    sep = (text_byte_i == dtep_pkg::CHAR_SPACE) || (text_byte_i == dtep_pkg::CHAR_COLON) ||
          (text_byte_i == dtep_pkg::CHAR_DASH);
    digit    = {{24{text_byte_i[7]}}, text_byte_i} - dtep_pkg::CHAR_ZERO;
    acc_step = sep ? 32'd0 : ((acc_q << 3) + (acc_q << 1) + digit);
  end

  // close on separator, then close again on the final character
  always_comb begin
    wr1_en = sep && (cnt_q < MaxCnt);
    cnt1   = cnt_q + dtep_pkg::CNT_W'(wr1_en);
    wr2_en = is_last_i && (cnt1 < MaxCnt);
    cnt2   = cnt1 + dtep_pkg::CNT_W'(wr2_en);
    for (int i = 0; i < int'(MaxFields); i++) begin
      if (wr2_en && (cnt1 == dtep_pkg::CNT_W'(i))) begin
        fld_fin[i] = acc_step;
      end else if (wr1_en && (cnt_q == dtep_pkg::CNT_W'(i))) begin
        fld_fin[i] = acc_q;
      end else begin
        fld_fin[i] = fld_q[i];
      end
    end
    acc_d = is_last_i ? 32'd0 : acc_step;
    cnt_d = is_last_i ? '0 : cnt1;
  end

  // fixed six-slot view of the fields
  for (genvar g = 0; g < int'(dtep_pkg::FIELD_SLOTS); g++) begin : g_slot
    if (g < int'(MaxFields)) begin : g_used
      assign slot[g] = fld_fin[g];
    end else begin : g_unused
      assign slot[g] = '0;
    end
  end

  // record of the closed string
  always_comb begin
    rec_o.year   = slot[0];
    rec_o.month  = slot[1][7:0];
    rec_o.day    = slot[2][7:0];
    rec_o.hour   = slot[3];
    rec_o.minute = slot[4];
    rec_o.second = slot[5];
    rec_o.count  = cnt2;
    push_o       = accept && is_last_i;
  end

  // tokenizer control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else if (accept) begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  // field store
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < int'(MaxFields); i++) begin
        fld_q[i] <= fld_fin[i];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dtep_queue.sv */
// ----------------------------------------------------------------------------
// dtep_queue: record queue between tokenizer and calendar unit
// Small first-in first-out buffer of closed strings.
// ----------------------------------------------------------------------------
`default_nettype none

module dtep_queue #(
  parameter int unsigned Depth = dtep_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire dtep_pkg::dtep_rec_t rec_i,
  input  wire logic                pop_i,
  output logic                     full_o,
  output logic                     empty_o,
  output dtep_pkg::dtep_rec_t      rec_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  dtep_pkg::dtep_rec_t mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  // status and head
  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign rec_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dtep_back.sv */
// ----------------------------------------------------------------------------
// dtep_back: calendar unit
// Turns one queued record into seconds since 1970 over a short sequence:
// days-from-civil with division by 25 done as a reciprocal multiply, then
// the time of day, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtep_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i,
  input  wire logic                empty_i,
  input  wire dtep_pkg::dtep_rec_t rec_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [63:0]              epoch_seconds_o,
  output logic                     too_few_fields_o
);

  localparam int unsigned DaysW = dtep_pkg::DAYS_W;
  localparam int unsigned TodW  = dtep_pkg::TOD_W;

  dtep_pkg::dtep_state_e state_q, state_d;
  logic                  incl_q;
  logic                  ld_out;

  dtep_pkg::dtep_rec_t       rec_q;
  logic signed [32:0]        yp_q, yp_d;
  logic signed [32:0]        q_q, q_d;
  logic [31:0]               x_q, x_d;
  logic [15:0]               t_q, t_d;
  logic                      le2;
  logic [8:0]                mm;
  logic [63:0]               prod_q, prod_d;
  logic signed [DaysW-1:0]   y365_q, y365_d;
  logic signed [14:0]        doy_q, doy_d;
  logic [32:0]               dprod;
  logic [TodW-1:0]           tod_q, tod_d;
  logic [43:0]               h_term;
  logic [37:0]               m_term;
  logic signed [28:0]        f25;
  logic signed [DaysW-1:0]   days_q, days_d;
  logic [63:0]               d64;
  logic [63:0]               secs;
  logic                      few;
  logic                      out_valid_q;
  logic [63:0]               epoch_q;
  logic                      few_q;

  // include_time register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      incl_q <= 1'b1;
    end else if (cfg_we_i) begin
      incl_q <= cfg_wdata_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtep_pkg::ST_IDLE: if (!empty_i) state_d = dtep_pkg::ST_PREP;
      dtep_pkg::ST_PREP: state_d = dtep_pkg::ST_MUL;
      dtep_pkg::ST_MUL:  state_d = dtep_pkg::ST_DAYS;
      dtep_pkg::ST_DAYS: state_d = dtep_pkg::ST_SEC;
      dtep_pkg::ST_SEC:  if (!out_valid_q || !out_stall_i) state_d = dtep_pkg::ST_IDLE;
      default:           state_d = dtep_pkg::ST_IDLE;
    endcase
  end

  // sequence controls
  always_comb begin
    pop_o  = (state_q == dtep_pkg::ST_IDLE) && !empty_i;
    ld_out = (state_q == dtep_pkg::ST_SEC) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtep_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // prep: shifted year, floor(y/4) with bias, month offset term
  always_comb begin
    le2 = (rec_q.month <= 8'd2);
    yp_d = $signed({rec_q.year[31], rec_q.year}) - (le2 ? 33'sd1 : 33'sd0);
    q_d  = yp_d >>> 2;
    x_d  = 32'(q_d + dtep_pkg::DIV25_BIAS);
    mm   = le2 ? (9'(rec_q.month) + 9'd9) : (9'(rec_q.month) - 9'd3);
    t_d  = 16'(mm) * 16'd153 + 16'd2;
  end

  // mul: reciprocal products, year times 365, time of day
  always_comb begin
    prod_d = {32'd0, x_q} * {32'd0, dtep_pkg::RECIP25};
    y365_d = DaysW'(yp_q) * 44'sd365;
    dprod  = {17'd0, t_q} * {16'd0, dtep_pkg::RECIP5};
    doy_d  = $signed({1'b0, dprod[32:19]}) + $signed({7'd0, rec_q.day}) - 15'sd1;
    h_term = {12'd0, rec_q.hour} * 44'd3600;
    m_term = {6'd0, rec_q.minute} * 38'd60;
    tod_d  = '0;
    if (incl_q) begin
      if (rec_q.count > 3'd3) tod_d = tod_d + TodW'(h_term);
      if (rec_q.count > 3'd4) tod_d = tod_d + TodW'(m_term);
      if (rec_q.count > 3'd5) tod_d = tod_d + TodW'(rec_q.second);
    end
  end

  // days: floor(y/100) and floor(y/400) from the biased quotient
  always_comb begin
    f25    = $signed({1'b0, prod_q[63:36]}) - $signed(dtep_pkg::DIV25_UNBIAS);
    days_d = y365_q + DaysW'(q_q) - DaysW'(f25) + DaysW'(f25 >>> 2) + DaysW'(doy_q)
             - dtep_pkg::EPOCH_SHIFT;
  end

  // sec: days times 86400 as shifted adds, plus time of day
  always_comb begin
    d64  = 64'(days_q);
    secs = (d64 << 16) + (d64 << 14) + (d64 << 12) + (d64 << 8) + (d64 << 7)
           + 64'(tod_q);
    few  = (rec_q.count < dtep_pkg::MIN_FIELDS);
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= rec_i;
    end
    if (state_q == dtep_pkg::ST_PREP) begin
      yp_q <= yp_d;
      q_q  <= q_d;
      x_q  <= x_d;
      t_q  <= t_d;
    end
    if (state_q == dtep_pkg::ST_MUL) begin
      prod_q <= prod_d;
      y365_q <= y365_d;
      doy_q  <= doy_d;
      tod_q  <= tod_d;
    end
    if (state_q == dtep_pkg::ST_DAYS) begin
      days_q <= days_d;
    end
    if (ld_out) begin
      epoch_q <= few ? 64'd0 : secs;
      few_q   <= few;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ld_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign epoch_seconds_o  = epoch_q;
  assign too_few_fields_o = few_q;

endmodule

`default_nettype wire
